### rtl/fqf_pkg.sv
// shared types and constants of the fastq index record filter
package fqf_pkg;

    localparam int FQF_HEADER_BYTES  = 512;
    localparam int FQF_PATTERN_CHARS = 8;

    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_A     = 2'd0,
        CFG_PATTERN_A_LEN = 2'd1,
        CFG_PATTERN_B     = 2'd2,
        CFG_PATTERN_B_LEN = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_RD   = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;      // input transaction this cycle
        logic rd_issue;  // read next header word
        logic rep_load;  // load read word into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hdr_keep_nl; // incoming byte closes a kept header
        logic out_busy;    // output register full and stalled
        logic rep_last;    // current replay word is the final one
    } t_stat;

endpackage

### rtl/fqf_ctrl.sv
// controller state machine: input acceptance and header replay sequencing
module fqf_ctrl import fqf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_stall,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        o_stall        = !((r_state == ST_RUN) && !i_stat.out_busy);
        o_cmd.take     = i_valid && !o_stall;
        o_cmd.rd_issue = (r_state == ST_RD) && !i_stat.out_busy;
        o_cmd.rep_load = (r_state == ST_LOAD);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (o_cmd.take && i_stat.hdr_keep_nl) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (o_cmd.rd_issue) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = i_stat.rep_last ? ST_RUN : ST_RD;
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/fqf_dp.sv
// datapath: line tracking, pattern search, header store and output register
module fqf_dp import fqf_pkg::*; #(
    parameter int HEADER_BYTES  = FQF_HEADER_BYTES,
    parameter int PATTERN_CHARS = FQF_PATTERN_CHARS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [BYTE_W-1:0]    i_in_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_W-1:0]    o_out_bytes,
    output logic [COUNT_W-1:0]   o_out_count,
    output logic                 o_out_is_header,
    output logic                 o_header_too_long,
    output logic                 o_out_last
);

    localparam int WORDS  = (HEADER_BYTES + 7) / 8;
    localparam int AW     = $clog2(WORDS);
    localparam int LW     = $clog2(HEADER_BYTES + 1);
    localparam int WIN_W  = 8 * PATTERN_CHARS;
    localparam int FILL_W = $clog2(PATTERN_CHARS + 1);

    // configuration
    logic [DATA_W-1:0]  r_pat_a, r_pat_b;
    logic [COUNT_W-1:0] r_len_a, r_len_b;

    // record state
    logic [1:0]        r_phase, n_phase;
    logic              r_keep, n_keep;
    logic [WIN_W-1:0]  r_win, n_win;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_seen_a, n_seen_a, r_seen_b, n_seen_b;
    logic [LW-1:0]     r_len, n_len;
    logic              r_ovf, n_ovf;
    logic [DATA_W-1:0] r_asm, n_asm;

    // replay
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]     r_rem, n_rem;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_mem [WORDS];

    // output register
    logic               r_valid, n_valid;
    logic [DATA_W-1:0]  r_bytes, n_bytes;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_is_hdr, n_is_hdr;
    logic               r_too_long, n_too_long;
    logic               r_last, n_last;

    logic          is_nl, hdr_phase, store, wr_en, hit_a, hit_b, nl_ovf;
    logic [2:0]    byte_sel;
    logic [AW-1:0] wr_addr;

    function automatic logic pattern_hit(input logic [WIN_W-1:0]  win,
                                         input logic [FILL_W-1:0] fill,
                                         input logic [WIN_W-1:0]  pat,
                                         input logic [COUNT_W-1:0] len_reg);
        logic [FILL_W-1:0] len_e;
        logic [WIN_W-1:0]  recent;
        logic [WIN_W-1:0]  mask;
        len_e = (len_reg > COUNT_W'(PATTERN_CHARS)) ? FILL_W'(PATTERN_CHARS)
                                                     : len_reg[FILL_W-1:0];
        recent = win >> {(FILL_W'(PATTERN_CHARS) - len_e), 3'b000};
        for (int k = 0; k < PATTERN_CHARS; k++) begin
            mask[8*k +: 8] = (FILL_W'(k) < len_e) ? 8'hFF : 8'h00;
        end
        return (len_reg == '0) ||
               ((fill >= len_e) && ((recent & mask) == (pat & mask)));
    endfunction

    always_comb begin
        is_nl     = (i_in_byte == NEWLINE_CHAR);
        hdr_phase = (r_phase == 2'd0);
        store     = (r_len < LW'(HEADER_BYTES));
        byte_sel  = r_len[2:0];
        wr_addr   = r_len[AW+2:3];
        n_asm     = ((byte_sel == 3'd0) ? '0 : r_asm) |
                    (DATA_W'(i_in_byte) << {byte_sel, 3'b000});
        wr_en     = i_cmd.take && hdr_phase && store && ((byte_sel == 3'd7) || is_nl);
        n_win     = (r_win >> 8) | (WIN_W'(i_in_byte) << (WIN_W - 8));
        n_fill    = (r_fill < FILL_W'(PATTERN_CHARS)) ? r_fill + 1'b1 : r_fill;
        hit_a     = pattern_hit(n_win, n_fill, r_pat_a[WIN_W-1:0], r_len_a);
        hit_b     = pattern_hit(n_win, n_fill, r_pat_b[WIN_W-1:0], r_len_b);
        n_seen_a  = r_seen_a || hit_a;
        n_seen_b  = r_seen_b || hit_b;
        nl_ovf    = r_ovf || !store;

        o_stat.hdr_keep_nl = hdr_phase && is_nl && !nl_ovf && n_seen_a && n_seen_b;
        o_stat.out_busy    = r_valid && i_stall;
        o_stat.rep_last    = (r_rem <= LW'(8));
    end

    // record and line state
    always_comb begin
        n_phase  = r_phase;
        n_keep   = r_keep;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_rd_ptr = r_rd_ptr;
        n_rem    = r_rem;
        if (i_cmd.take) begin
            if (!hdr_phase) begin
                if (is_nl) begin
                    n_phase = r_phase + 2'd1;
                end
            end else if (is_nl) begin
                n_keep   = o_stat.hdr_keep_nl;
                n_phase  = 2'd1;
                n_len    = '0;
                n_ovf    = 1'b0;
                n_rd_ptr = '0;
                n_rem    = r_len + 1'b1;
            end else begin
                n_len = store ? r_len + 1'b1 : r_len;
                n_ovf = nl_ovf;
            end
        end
        if (i_cmd.rep_load) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
            n_rem    = o_stat.rep_last ? '0 : r_rem - LW'(8);
        end
    end

    // output register
    always_comb begin
        n_valid    = r_valid && i_stall;
        n_bytes    = r_bytes;
        n_count    = r_count;
        n_is_hdr   = r_is_hdr;
        n_too_long = r_too_long;
        n_last     = r_last;
        if (i_cmd.take && !hdr_phase && r_keep) begin
            n_valid    = 1'b1;
            n_bytes    = DATA_W'(i_in_byte);
            n_count    = COUNT_W'(1);
            n_is_hdr   = 1'b0;
            n_too_long = 1'b0;
            n_last     = 1'b1;
        end else if (i_cmd.take && hdr_phase && is_nl && nl_ovf) begin
            n_valid    = 1'b1;
            n_bytes    = '0;
            n_count    = '0;
            n_is_hdr   = 1'b0;
            n_too_long = 1'b1;
            n_last     = 1'b1;
        end else if (i_cmd.rep_load) begin
            n_valid    = 1'b1;
            n_bytes    = r_rd_data;
            n_count    = o_stat.rep_last ? r_rem[COUNT_W-1:0] : COUNT_W'(8);
            n_is_hdr   = 1'b1;
            n_too_long = 1'b0;
            n_last     = o_stat.rep_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_a <= '0;
            r_pat_b <= '0;
            r_len_a <= '0;
            r_len_b <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PATTERN_A:     r_pat_a <= i_cfg_data;
                CFG_PATTERN_A_LEN: r_len_a <= i_cfg_data[COUNT_W-1:0];
                CFG_PATTERN_B:     r_pat_b <= i_cfg_data;
                CFG_PATTERN_B_LEN: r_len_b <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_keep   <= 1'b0;
            r_win    <= '0;
            r_fill   <= '0;
            r_seen_a <= 1'b0;
            r_seen_b <= 1'b0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_rd_ptr <= '0;
            r_rem    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_keep   <= n_keep;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_rd_ptr <= n_rd_ptr;
            r_rem    <= n_rem;
            r_valid  <= n_valid;
            if (i_cmd.take && hdr_phase) begin
                if (is_nl) begin
                    r_win    <= '0;
                    r_fill   <= '0;
                    r_seen_a <= 1'b0;
                    r_seen_b <= 1'b0;
                end else begin
                    r_win    <= n_win;
                    r_fill   <= n_fill;
                    r_seen_a <= n_seen_a;
                    r_seen_b <= n_seen_b;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bytes    <= n_bytes;
        r_count    <= n_count;
        r_is_hdr   <= n_is_hdr;
        r_too_long <= n_too_long;
        r_last     <= n_last;
        if (i_cmd.take && hdr_phase && store) begin
            r_asm <= n_asm;
        end
    end

    // header store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= n_asm;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_valid           = r_valid;
    assign o_out_bytes       = r_bytes;
    assign o_out_count       = r_count;
    assign o_out_is_header   = r_is_hdr;
    assign o_header_too_long = r_too_long;
    assign o_out_last        = r_last;

endmodule

### rtl/fastq_index_record_filter.sv
// top level of the fastq index record filter
//
// input channel: one text byte per transaction (i_valid / o_stall, i_in_byte)
// output channel: up to 8 characters per transaction (o_valid / i_stall)
// config port: i_cfg_we, i_cfg_idx, i_cfg_data; write only while idle
// lines are counted in fours; the first is the header, buffered in a
//   word-wide store while both index patterns are searched in it
// body byte of a kept record: result in the cycle after its transaction
// header byte: one per cycle unless stalled, no result until its newline
// kept header: replayed in 8-byte words; after the newline each word is
//   read from the store, then loaded into the output register, one word
//   after another; input is stalled for the whole replay
// over-long header: one marker result with header_too_long, record dropped
// receiver stall: the output register holds; input stalls while it is full and stalled
// reset: synchronous, clears patterns, line count and output valid; no
//   clearing pass, the store is written before it is read
module fastq_index_record_filter import fqf_pkg::*; #(
    parameter int HEADER_BYTES  = FQF_HEADER_BYTES,
    parameter int PATTERN_CHARS = FQF_PATTERN_CHARS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte stream
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_in_byte,
    // result stream
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_W-1:0]    o_out_bytes,
    output logic [COUNT_W-1:0]   o_out_count,
    output logic                 o_out_is_header,
    output logic                 o_header_too_long,
    output logic                 o_out_last,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing: acceptance and replay steps
    fqf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // search, header store and output register
    fqf_dp #(
        .HEADER_BYTES  (HEADER_BYTES),
        .PATTERN_CHARS (PATTERN_CHARS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_in_byte         (i_in_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_bytes       (o_out_bytes),
        .o_out_count       (o_out_count),
        .o_out_is_header   (o_out_is_header),
        .o_header_too_long (o_header_too_long),
        .o_out_last        (o_out_last)
    );

endmodule
